[hw/rtl/skset_pkg.sv]
// Package for the sorted key set: request kinds, sequencer states,
// key sentinels and the compare result type. No dependencies.
package skset_pkg;

  localparam int KeyW = 32;

  localparam logic signed [KeyW-1:0] KEY_LOW_SENTINEL  = 32'sh8000_0000;
  localparam logic signed [KeyW-1:0] KEY_HIGH_SENTINEL = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_CONTAINS = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PROBE,
    ST_CHECK,
    ST_APPLY,
    ST_INS,
    ST_INS_WR,
    ST_DEL,
    ST_DEL_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

[hw/rtl/skset_mem.sv]
// Key storage for the sorted key set: one write port, one registered read port.
// Depends on nothing but its parameters.
module skset_mem #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/skset_cmp.sv]
// Shared signed key comparator of the sorted key set.
// Depends on skset_pkg for the key width and result struct.
module skset_cmp (
  input  logic signed [skset_pkg::KeyW-1:0] a_i,
  input  logic signed [skset_pkg::KeyW-1:0] b_i,
  output skset_pkg::cmp_res_t               res_o
);
  import skset_pkg::*;

  always_comb begin
    res_o.lt = (a_i < b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

[hw/rtl/sorted_key_set.sv]
// Top level of the sorted key set: request sequencer, binary search and shift loops.
// Depends on skset_pkg, skset_mem and skset_cmp.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------
//   request | in        | in_valid_i / in_ready_o | kind_i, key_i
//   result  | out       | out_valid_o / out_ready_i | ok_o, full_res_o
//
// One request at a time. Ready is high only while the sequencer is idle.
// A request runs through the binary search steps (ceil(log2(occupancy+1))
// steps, each a read then a compare on the single memory read port), the
// hit check, and a read then a write per key moved by an add or remove,
// besides the accept, last search step, apply and result states, and a
// final insert or delete state when the set changes.
// Unused kinds and sentinel keys skip the search and go straight to the result.
// Reset clears the occupancy and the control state; the key memory keeps
// no reset, entries at or beyond the occupancy are never read.
// A finished result sits in the output register until taken; the next
// request is accepted meanwhile and waits at its end if the result is still held.
module sorted_key_set #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        kind_i,
  input  logic signed [skset_pkg::KeyW-1:0] key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              ok_o,
  output logic                              full_res_o
);
  import skset_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
  localparam logic [CW-1:0] One      = CW'(1);

  state_e state_q, state_d;

  logic [CW-1:0] occ_q, occ_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] mid_q, mid_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [1:0]    kind_q, kind_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic          found_q, found_d;
  logic          res_ok_q, res_ok_d;
  logic          res_full_q, res_full_d;
  logic          out_valid_q, out_valid_d;
  logic          ok_q, ok_d;
  logic          full_q, full_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [KeyW-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [KeyW-1:0] mem_rdata;
  cmp_res_t        cmp_res;

  logic [CW-1:0] mid_calc;
  logic [CW-1:0] ptr_dec;
  logic [CW-1:0] ptr_inc;

  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);
  assign ptr_dec  = ptr_q - One;
  assign ptr_inc  = ptr_q + One;

  skset_mem #(
    .Depth(CAPACITY),
    .Width(KeyW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // One comparator serves every search probe and the hit check.
  skset_cmp u_cmp (
    .a_i  (mem_rdata),
    .b_i  (key_q),
    .res_o(cmp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    ptr_q      <= ptr_d;
    kind_q     <= kind_d;
    key_q      <= key_d;
    found_q    <= found_d;
    res_ok_q   <= res_ok_d;
    res_full_q <= res_full_d;
    ok_q       <= ok_d;
    full_q     <= full_d;
  end

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    ptr_d       = ptr_q;
    kind_d      = kind_q;
    key_d       = key_q;
    found_d     = found_q;
    res_ok_d    = res_ok_q;
    res_full_d  = res_full_q;
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    full_d      = full_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = mid_calc[AW-1:0];
    in_ready_o  = 1'b0;

    // Drop the held result once the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d     = kind_i;
          key_d      = key_i;
          res_ok_d   = 1'b0;
          res_full_d = 1'b0;
          found_d    = 1'b0;
          lo_d       = '0;
          hi_d       = occ_q;
          // Unused kinds and sentinel keys leave the set untouched.
          if (kind_i > KIND_CONTAINS || key_i == KEY_LOW_SENTINEL ||
              key_i == KEY_HIGH_SENTINEL) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          // Probe the midpoint of the open range.
          mem_re    = 1'b1;
          mem_raddr = mid_calc[AW-1:0];
          mid_d     = mid_calc;
          state_d   = ST_PROBE;
        end else if (lo_q < occ_q) begin
          mem_re    = 1'b1;
          mem_raddr = lo_q[AW-1:0];
          state_d   = ST_CHECK;
        end else begin
          found_d = 1'b0;
          state_d = ST_APPLY;
        end
      end

      ST_PROBE: begin
        if (cmp_res.lt) begin
          lo_d = mid_q + One;
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SEARCH;
      end

      ST_CHECK: begin
        found_d = cmp_res.eq;
        state_d = ST_APPLY;
      end

      ST_APPLY: begin
        state_d = ST_DONE;
        case (kind_q)
          KIND_ADD: begin
            if (!found_q) begin
              if (occ_q == CapCount) begin
                res_full_d = 1'b1;
              end else begin
                ptr_d   = occ_q;
                state_d = ST_INS;
              end
            end
          end
          KIND_REMOVE: begin
            if (found_q) begin
              ptr_d   = lo_q;
              state_d = ST_DEL;
            end
          end
          KIND_CONTAINS: begin
            res_ok_d = found_q;
          end
          default: begin
            res_ok_d = 1'b0;
          end
        endcase
      end

      // Open a slot: advance each key above the insert point up by one.
      ST_INS: begin
        if (ptr_q > lo_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_dec[AW-1:0];
          state_d   = ST_INS_WR;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = lo_q[AW-1:0];
          mem_wdata = key_q;
          occ_d     = occ_q + One;
          res_ok_d  = 1'b1;
          state_d   = ST_DONE;
        end
      end

      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AW-1:0];
        mem_wdata = mem_rdata;
        ptr_d     = ptr_dec;
        state_d   = ST_INS;
      end

      // Close the gap: pull each key above the hit down by one.
      ST_DEL: begin
        if (ptr_inc < occ_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[AW-1:0];
          state_d   = ST_DEL_WR;
        end else begin
          occ_d    = occ_q - One;
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end
      end

      ST_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AW-1:0];
        mem_wdata = mem_rdata;
        ptr_d     = ptr_inc;
        state_d   = ST_DEL;
      end

      // Hold here until the output register is free.
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ok_d        = res_ok_q;
          full_d      = res_full_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign full_res_o  = full_q;

endmodule

[sim/sorted_key_set_test.sv]
// Self-checking testbench for sorted_key_set: directed corner requests, a fill-to-full
// sequence, a back-pressure stretch and phased random traffic, all checked against a model.
// Depends on skset_pkg and the sorted_key_set RTL.
`timescale 1ns / 1ps

module sorted_key_set_test;
  import skset_pkg::*;

  localparam int CAPACITY = 64;
  localparam int POOL_SIZE = 80;          // a bit more than CAPACITY so the store can fill up
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off for the pressure test
  localparam int TAIL_CYCLES = 2 * CAPACITY + 40;

  // Request code that the block must answer with a null result.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Largest and smallest storable keys, just inside the sentinels.
  localparam logic signed [KeyW-1:0] KEY_MIN = 32'sh8000_0001;
  localparam logic signed [KeyW-1:0] KEY_MAX = 32'sh7FFF_FFFE;

  typedef struct packed {
    logic ok;
    logic full_res;
  } set_result_t;

  // DUT-facing signals; the ones the bench drives are known from time zero.
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             kind_i = KIND_ADD;
  logic signed [KeyW-1:0] key_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   ok_o;
  logic                   full_res_o;

  // Model state: the keys the block should hold, kept in ascending order.
  logic signed [KeyW-1:0] held_keys[$];
  // Results owed by the block, oldest first.
  set_result_t            pending_results[$];

  int  error_count = 0;
  bit  pace_gaps = 1'b1;        // sender inserts idle gaps
  bit  sink_may_stall = 1'b1;   // receiver drops ready at random
  int  hold_off_requests = 0;   // bumped by a test to ask for one long receiver hold-off
  int  hold_off_served = 0;
  int  sink_stall_left = 0;

  sorted_key_set #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ok_o       (ok_o),
    .full_res_o (full_res_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Backstop against a hung block: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("sorted_key_set_test failed");
    $finish;
  end

  // Idle length for either side: mostly short, now and then a long one.
  function automatic int idle_gap();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(0, 3);
  endfunction

  // Membership of a key in the model set, without changing it.
  function automatic bit apply_probe(input logic signed [KeyW-1:0] key);
    foreach (held_keys[i]) begin
      if (held_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one request to the model set and return what the block must answer.
  function automatic set_result_t apply_request(input logic [1:0] kind,
                                                input logic signed [KeyW-1:0] key);
    set_result_t res;
    int          pos;
    logic        hit;
    res = '0;
    // Unused kinds and sentinel keys never touch the set.
    if (kind == KIND_UNUSED || key == KEY_LOW_SENTINEL || key == KEY_HIGH_SENTINEL) begin
      return res;
    end
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] < key) pos++;
    hit = (pos < held_keys.size()) && (held_keys[pos] == key);
    case (kind)
      KIND_ADD: begin
        // A duplicate is refused without the full flag, even on a full store.
        if (!hit) begin
          if (held_keys.size() >= CAPACITY) begin
            res.full_res = 1'b1;
          end else begin
            held_keys.insert(pos, key);
            res.ok = 1'b1;
          end
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          held_keys.delete(pos);
          res.ok = 1'b1;
        end
      end
      default: begin
        res.ok = hit;
      end
    endcase
    return res;
  endfunction

  // Offer one request, hold it until the transfer, then record the owed result.
  // Valid stays high on return, so a back-to-back request needs no extra edge;
  // callers that stop sending lower it through wait_drained.
  task automatic send_req(input logic [1:0] kind, input logic signed [KeyW-1:0] key);
    int gap;
    gap = pace_gaps ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(apply_request(kind, key));
  endtask

  // Drop valid and pause the sender until every owed result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result sink: random stalls, plus one long hold-off per request from a test.
  always @(posedge clk_i) begin : result_sink
    if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      sink_stall_left = HOLD_OFF_CYCLES;
    end else if (sink_stall_left == 0 && sink_may_stall && $urandom_range(0, 3) == 0) begin
      sink_stall_left = idle_gap();
    end
    if (sink_stall_left > 0) begin
      out_ready_i <= 1'b0;
      sink_stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker: every transfer on the result side must match the oldest owed result.
  always @(posedge clk_i) begin : result_check
    set_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: ok=%0b full_res=%0b", ok_o, full_res_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0b, actual %0b", want.ok, ok_o);
          error_count++;
        end
        if (full_res_o !== want.full_res) begin
          $error("full_res: expected %0b, actual %0b", want.full_res, full_res_o);
          error_count++;
        end
      end
    end
  end

  // Corner requests: empty store, extreme keys, duplicates, sentinels and the unused kind.
  task automatic test_corner_requests();
    send_req(KIND_CONTAINS, KEY_MIN);
    send_req(KIND_REMOVE, KEY_MAX);
    send_req(KIND_ADD, KEY_MIN);
    send_req(KIND_ADD, KEY_MAX);
    send_req(KIND_ADD, 32'sd0);
    send_req(KIND_ADD, -32'sd1);
    send_req(KIND_ADD, 32'sd1);
    send_req(KIND_ADD, 32'sd0);            // duplicate
    send_req(KIND_CONTAINS, KEY_MIN);
    send_req(KIND_CONTAINS, KEY_MAX);
    send_req(KIND_CONTAINS, 32'sd5);       // miss between held keys
    // Sentinels are never stored, whatever the request.
    send_req(KIND_ADD, KEY_LOW_SENTINEL);
    send_req(KIND_ADD, KEY_HIGH_SENTINEL);
    send_req(KIND_REMOVE, KEY_LOW_SENTINEL);
    send_req(KIND_CONTAINS, KEY_HIGH_SENTINEL);
    // Unused kind on a held key: null answer, key stays.
    send_req(KIND_UNUSED, 32'sd0);
    send_req(KIND_CONTAINS, 32'sd0);
    send_req(KIND_REMOVE, 32'sd0);
    send_req(KIND_REMOVE, 32'sd0);         // already gone
    send_req(KIND_CONTAINS, 32'sd0);
    send_req(KIND_REMOVE, KEY_MAX);
    send_req(KIND_REMOVE, KEY_MIN);
    send_req(KIND_REMOVE, -32'sd1);
    send_req(KIND_REMOVE, 32'sd1);
    wait_drained();
  endtask

  // Fill the store with random keys, probe the full refusal, then empty it again.
  task automatic test_full_store();
    logic signed [KeyW-1:0] fresh;
    while (held_keys.size() < CAPACITY) begin
      send_req(KIND_ADD, $urandom);
    end
    // A storable key that is not held, so the add meets the full store.
    do fresh = $urandom;
    while (apply_probe(fresh) || fresh == KEY_LOW_SENTINEL || fresh == KEY_HIGH_SENTINEL);
    send_req(KIND_ADD, fresh);                                   // refused, full flag
    send_req(KIND_ADD, held_keys[$urandom_range(0, CAPACITY - 1)]); // duplicate on full
    send_req(KIND_ADD, KEY_HIGH_SENTINEL);                       // sentinel on full
    send_req(KIND_CONTAINS, held_keys[0]);
    send_req(KIND_CONTAINS, held_keys[CAPACITY - 1]);
    send_req(KIND_REMOVE, held_keys[CAPACITY / 2]);
    send_req(KIND_ADD, fresh);                                   // room again
    // Empty in random order, with a few lookups along the way.
    while (held_keys.size() > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        send_req(KIND_CONTAINS, held_keys[$urandom_range(0, held_keys.size() - 1)]);
      end
      send_req(KIND_REMOVE, held_keys[$urandom_range(0, held_keys.size() - 1)]);
    end
    wait_drained();
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so the block
  // parks a finished result, takes one more request and then stalls its input.
  task automatic test_back_pressure();
    pace_gaps = 1'b0;
    hold_off_requests++;
    for (int i = 0; i < 10; i++) begin
      send_req((i % 2 == 0) ? KIND_ADD : KIND_CONTAINS, $urandom_range(0, 15));
    end
    wait_drained();
    pace_gaps = 1'b1;
  endtask

  // Phased random traffic over a small key pool so that hits, refills and full refusals
  // are common. Phases cycle through fill-heavy, balanced and drain-heavy mixes.
  task automatic test_random_traffic(input int num_items);
    logic signed [KeyW-1:0] pool[POOL_SIZE];
    logic [1:0]             kind;
    logic signed [KeyW-1:0] key;
    int                     add_pct;
    int                     roll;
    int                     phase;
    pool[0] = KEY_MIN;
    pool[1] = KEY_MAX;
    pool[2] = 32'sd0;
    pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) pool[i] = $urandom;
    for (int n = 0; n < num_items; n++) begin
      if (n % 100 == 0) begin
        phase = n / 100;
        case (phase % 3)
          0:       add_pct = 75;
          1:       add_pct = 50;
          default: add_pct = 20;
        endcase
        // Leave some phases free of idle cycles on one side or the other.
        pace_gaps      = (phase % 4 != 3);
        sink_may_stall = (phase % 5 != 4);
        // Every fourth phase boundary, pause the sender until all results are back.
        if (phase % 4 == 0 && phase != 0) wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < add_pct) kind = KIND_ADD;
      else if (roll < add_pct + (100 - add_pct) / 2) kind = KIND_REMOVE;
      else kind = KIND_CONTAINS;
      if ($urandom_range(0, 63) == 0) kind = KIND_UNUSED;
      roll = $urandom_range(0, 31);
      if (roll == 0) key = $urandom_range(0, 1) ? KEY_LOW_SENTINEL : KEY_HIGH_SENTINEL;
      else if (roll <= 4) key = $urandom;
      else key = pool[$urandom_range(0, POOL_SIZE - 1)];
      send_req(kind, key);
    end
    wait_drained();
    pace_gaps      = 1'b1;
    sink_may_stall = 1'b1;
  endtask

  initial begin : main
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_requests();
    test_full_store();
    test_back_pressure();
    test_random_traffic(1250);

    // Let any stray result show up before the verdict.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sorted_key_set_test passed");
    end else begin
      $display("sorted_key_set_test failed");
    end
    $finish;
  end

endmodule
